FILE: src/ngts_pkg.sv
`timescale 1ns / 1ps

package ngts_pkg;

    localparam int unsigned MaxTextBytes = 65536;
    localparam int unsigned OfsW         = $clog2(MaxTextBytes + 1);
    localparam int unsigned ResMax       = 3;
    localparam int unsigned QDepth       = 8;
    localparam int unsigned QPtrW        = $clog2(QDepth);
    localparam int unsigned QCntW        = $clog2(QDepth + 1);
    localparam int unsigned ResCntW      = $clog2(ResMax + 1);

    localparam logic [2:0] GramReset = 3'd2;
    localparam logic [2:0] GramMin   = 3'd1;
    localparam logic [2:0] GramMax   = 3'd4;

    typedef logic [OfsW-1:0] t_ofs;

    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CAT_DIGIT = 2'd0,
        CAT_SPACE = 2'd1,
        CAT_ALPHA = 2'd2,
        CAT_OTHER = 2'd3
    } t_cat;

    typedef struct packed {
        t_ofs       byte_offset;
        t_ofs       token_begin;
        logic [2:0] unit_count;
        t_cat       run_category;
        logic       run_open;
        logic [1:0] bytes_to_skip;
        logic       dropping_text;
    } t_state;

    typedef struct packed {
        t_ofs  token_start;
        t_ofs  token_end;
        t_kind result_kind;
        logic  last_result;
    } t_result;

    localparam t_state StateClear = '{
        byte_offset:   '0,
        token_begin:   '0,
        unit_count:    '0,
        run_category:  CAT_DIGIT,
        run_open:      1'b0,
        bytes_to_skip: '0,
        dropping_text: 1'b0
    };

    function automatic t_cat classify(input logic [7:0] b);
        t_cat c;
        if (b >= 8'h30 && b <= 8'h39) begin
            c = CAT_DIGIT;
        end else if (b <= 8'h20 || b == 8'h7F) begin
            c = CAT_SPACE;
        end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            c = CAT_ALPHA;
        end else begin
            c = CAT_OTHER;
        end
        return c;
    endfunction

    // Zero means the byte cannot start a character.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80) begin
            len = 3'd1;
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF7) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

FILE: src/ngram_token_splitter_unit.sv
`timescale 1ns / 1ps

// Character n-gram token splitter.
// Input channel: one text byte per transfer with an end-of-text mark,
// handshaked by i_valid and o_stall. Output channel: token offsets and
// status results, handshaked by o_valid and i_stall. Each text yields its
// tokens followed by one result with o_last_result set (done or error).
// The gram size register is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle, which is not enforced.
// A byte taken is registered, processed by the step logic, and its results
// are written into the result queue, whose head drives the output.
// Throughput: one byte per cycle while o_stall is low. A byte makes zero
// to three results that leave one per cycle, while i_stall is low, through
// an eight-entry result queue; o_stall rises while more than two results
// wait, so bytes that make several results slow the input to the output rate.
// Reset clears the text state and the queue and sets the gram size to 2.
// A stalled receiver keeps the head result steady; the queue absorbs the
// results of bytes already taken.
module ngram_token_splitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_token_start,
    output logic [16:0] o_token_end,
    output logic [1:0]  o_result_kind,
    output logic        o_last_result
);
    import ngts_pkg::*;

    logic [2:0]          r_gram_size;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eot;
    t_state              r_state;
    t_state              n_state;
    t_result [ResMax-1:0] w_res;
    logic [ResCntW-1:0]  w_res_count;
    logic [ResCntW-1:0]  w_push_count;
    t_result             w_head;
    logic                w_room;
    logic                w_accept;

    assign o_stall  = !w_room;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_size <= GramReset;
        end else if (i_cfg_we) begin
            r_gram_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateClear;
        end else if (r_in_valid) begin
            r_state <= n_state;
        end
    end

    ngts_step u_step (
        .i_state       (r_state),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .i_gram_size   (r_gram_size),
        .o_state       (n_state),
        .o_res         (w_res),
        .o_res_count   (w_res_count)
    );

    assign w_push_count = r_in_valid ? w_res_count : '0;

    ngts_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (w_res),
        .i_push_count (w_push_count),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_head       (w_head),
        .o_room       (w_room)
    );

    assign o_token_start = w_head.token_start;
    assign o_token_end   = w_head.token_end;
    assign o_result_kind = w_head.result_kind;
    assign o_last_result = w_head.last_result;

endmodule

FILE: src/ngts_step.sv
`timescale 1ns / 1ps

module ngts_step (
    input  ngts_pkg::t_state                     i_state,
    input  logic [7:0]                           i_text_byte,
    input  logic                                 i_end_of_text,
    input  logic [2:0]                           i_gram_size,
    output ngts_pkg::t_state                     o_state,
    output ngts_pkg::t_result [ngts_pkg::ResMax-1:0] o_res,
    output logic [ngts_pkg::ResCntW-1:0]         o_res_count
);
    import ngts_pkg::*;

    logic [2:0]          w_gram;
    t_cat                w_cat;
    logic [2:0]          w_len;
    logic                w_skip;
    logic                w_start;
    logic                w_emit;
    logic                w_bad;
    t_ofs                w_tb;
    logic [2:0]          w_uc;
    logic [1:0]          w_bts;
    t_ofs                w_bo;
    t_result             w_tok_a;
    t_result             w_tok_b;
    t_result             w_err;
    t_result             w_done;
    logic [ResCntW-1:0]  w_n;

    always_comb begin
        if (i_gram_size < GramMin) begin
            w_gram = GramMin;
        end else if (i_gram_size > GramMax) begin
            w_gram = GramMax;
        end else begin
            w_gram = i_gram_size;
        end

        w_cat   = classify(i_text_byte);
        w_len   = lead_length(i_text_byte);
        w_skip  = (i_state.bytes_to_skip != 2'd0);
        w_start = !w_skip && !(i_state.run_open && w_cat != CAT_OTHER
                               && w_cat == i_state.run_category);
        w_emit  = w_start && (i_state.unit_count >= w_gram);
        w_bad   = w_start && (w_cat == CAT_OTHER) && (w_len == 3'd0);

        w_tb = w_emit ? i_state.byte_offset : i_state.token_begin;
        w_uc = w_emit ? 3'd0 : i_state.unit_count;
        if (w_start && w_cat != CAT_SPACE) begin
            w_uc = w_uc + 3'd1;
        end

        if (w_skip) begin
            w_bts = i_state.bytes_to_skip - 2'd1;
        end else if (w_start && w_cat == CAT_OTHER) begin
            w_bts = w_len[1:0] - 2'd1;
        end else begin
            w_bts = 2'd0;
        end

        w_bo = (i_state.byte_offset < OfsW'(MaxTextBytes))
             ? i_state.byte_offset + t_ofs'(1) : i_state.byte_offset;

        w_tok_a = '{token_start: i_state.token_begin, token_end: i_state.byte_offset,
                    result_kind: KIND_TOKEN, last_result: 1'b0};
        w_tok_b = '{token_start: w_tb, token_end: w_bo,
                    result_kind: KIND_TOKEN, last_result: 1'b0};
        w_err   = '{token_start: '0, token_end: '0,
                    result_kind: KIND_ERROR, last_result: 1'b1};
        w_done  = '{token_start: '0, token_end: '0,
                    result_kind: KIND_DONE, last_result: 1'b1};

        o_state = i_state;
        o_res   = '{default: w_done};
        w_n     = '0;

        if (i_state.dropping_text) begin
            if (i_end_of_text) begin
                o_state = StateClear;
            end
        end else if (w_bad) begin
            if (w_emit) begin
                o_res[w_n] = w_tok_a;
                w_n = w_n + ResCntW'(1);
            end
            o_res[w_n] = w_err;
            w_n = w_n + ResCntW'(1);
            if (i_end_of_text) begin
                o_state = StateClear;
            end else begin
                o_state.dropping_text = 1'b1;
            end
        end else begin
            if (w_emit) begin
                o_res[w_n] = w_tok_a;
                w_n = w_n + ResCntW'(1);
            end
            o_state.byte_offset   = w_bo;
            o_state.token_begin   = w_tb;
            o_state.unit_count    = w_uc;
            o_state.bytes_to_skip = w_bts;
            if (w_start) begin
                o_state.run_open     = (w_cat != CAT_OTHER);
                o_state.run_category = w_cat;
            end
            if (i_end_of_text) begin
                if (w_bts != 2'd0) begin
                    o_res[w_n] = w_err;
                    w_n = w_n + ResCntW'(1);
                end else begin
                    if (w_uc != 3'd0) begin
                        o_res[w_n] = w_tok_b;
                        w_n = w_n + ResCntW'(1);
                    end
                    o_res[w_n] = w_done;
                    w_n = w_n + ResCntW'(1);
                end
                o_state = StateClear;
            end
        end

        o_res_count = w_n;
    end

endmodule

FILE: src/ngts_result_fifo.sv
`timescale 1ns / 1ps

module ngts_result_fifo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ngts_pkg::t_result [ngts_pkg::ResMax-1:0] i_res,
    input  logic [ngts_pkg::ResCntW-1:0]         i_push_count,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output ngts_pkg::t_result                    o_head,
    output logic                                 o_room
);
    import ngts_pkg::*;

    t_result            r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QCntW-1:0]   r_count;
    logic               w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_head  = r_mem[r_rd_ptr];

    // Room for the results of one byte in flight and of one more byte being accepted.
    assign o_room = (r_count <= QCntW'(QDepth - 2 * ResMax));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ResMax; i++) begin
            if (i < int'(i_push_count)) begin
                r_mem[r_wr_ptr + QPtrW'(i)] <= i_res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPtrW'(i_push_count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            r_count <= r_count + QCntW'(i_push_count) - QCntW'(w_pop);
        end
    end

endmodule

FILE: src/ngts_checker.sv
`timescale 1ns / 1ps

module ngts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [16:0] o_token_start,
    input  logic [16:0] o_token_end,
    input  logic [1:0]  o_result_kind,
    input  logic        o_last_result
);
    import ngts_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_start)
            && $stable(o_token_end) && $stable(o_result_kind)
            && $stable(o_last_result))
        else $error("stalled result changed");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_TOKEN |->
            o_token_start == '0 && o_token_end == '0)
        else $error("status result carries offsets");

    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_result == (o_result_kind != KIND_TOKEN))
            && (o_result_kind == KIND_TOKEN || o_result_kind == KIND_DONE
                || o_result_kind == KIND_ERROR))
        else $error("last mark does not match result kind");

    a_token_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_TOKEN |-> o_token_start <= o_token_end)
        else $error("token ends before it starts");

endmodule

bind ngram_token_splitter_unit ngts_checker u_ngts_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ngts_pkg::*;

    localparam int unsigned CycleLimit   = 1000000;
    localparam int unsigned SettleCycles = 6;
    localparam int unsigned RandomBytes  = 245;
    localparam int unsigned PhaseBytes   = 35;

    localparam logic [7:0] Punct [8] = '{8'h21, 8'h2D, 8'h2E, 8'h40,
                                         8'h5B, 8'h60, 8'h7B, 8'h7E};
    localparam logic [2:0] GramPlan [8] = '{3'd7, 3'd3, 3'd0, 3'd2,
                                            3'd5, 3'd1, 3'd4, 3'd6};

    class token_tracker;
        logic [2:0]  gram;
        t_ofs        offset;
        t_ofs        begin_ofs;
        logic [2:0]  units;
        t_cat        run_cat;
        bit          run_open;
        logic [1:0]  skip;
        bit          dropping;
        t_result     expected_q[$];
        int unsigned mismatches;

        function new();
            gram       = GramReset;
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            offset    = '0;
            begin_ofs = '0;
            units     = '0;
            run_cat   = CAT_DIGIT;
            run_open  = 1'b0;
            skip      = '0;
            dropping  = 1'b0;
        endfunction

        function t_cat char_class(logic [7:0] b);
            case (b) inside
                [8'h30:8'h39]:                return CAT_DIGIT;
                [8'h00:8'h20], 8'h7F:         return CAT_SPACE;
                [8'h41:8'h5A], [8'h61:8'h7A]: return CAT_ALPHA;
                default:                      return CAT_OTHER;
            endcase
        endfunction

        function int unsigned seq_length(logic [7:0] b);
            case (b) inside
                [8'h00:8'h7F]: return 1;
                [8'hC0:8'hDF]: return 2;
                [8'hE0:8'hEF]: return 3;
                [8'hF0:8'hF7]: return 4;
                default:       return 0;
            endcase
        endfunction

        function void push(t_ofs s, t_ofs e, t_kind k, logic l);
            t_result r;
            r.token_start = s;
            r.token_end   = e;
            r.result_kind = k;
            r.last_result = l;
            expected_q.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic eot);
            int unsigned g;
            int unsigned len;
            t_cat        c;
            bit          joins;
            g = (gram == 3'd0) ? 1 : ((gram > 3'd4) ? 4 : int'(gram));
            if (dropping) begin
                if (eot) clear_text();
                return;
            end
            if (skip != 2'd0) begin
                skip = skip - 2'd1;
            end else begin
                c     = char_class(b);
                joins = run_open && c != CAT_OTHER && c == run_cat;
                if (!joins) begin
                    if (units >= g) begin
                        push(begin_ofs, offset, KIND_TOKEN, 1'b0);
                        begin_ofs = offset;
                        units     = '0;
                    end
                    if (c == CAT_OTHER) begin
                        len = seq_length(b);
                        if (len == 0) begin
                            push('0, '0, KIND_ERROR, 1'b1);
                            if (eot) clear_text();
                            else dropping = 1'b1;
                            return;
                        end
                        skip     = 2'(len - 1);
                        run_open = 1'b0;
                        run_cat  = CAT_OTHER;
                    end else begin
                        run_open = 1'b1;
                        run_cat  = c;
                    end
                    if (c != CAT_SPACE) units = units + 3'd1;
                end
            end
            if (32'(offset) < MaxTextBytes) offset = offset + 1'b1;
            if (eot) begin
                if (skip != 2'd0) begin
                    push('0, '0, KIND_ERROR, 1'b1);
                end else begin
                    if (units != 3'd0) push(begin_ofs, offset, KIND_TOKEN, 1'b0);
                    push('0, '0, KIND_DONE, 1'b1);
                end
                clear_text();
            end
        endfunction

        function void note_mismatch(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void match_result(logic [16:0] s, logic [16:0] e, logic [1:0] k, logic l);
            t_result r;
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result kind", 3, k);
                return;
            end
            r = expected_q.pop_front();
            if (s !== r.token_start) note_mismatch("token_start", r.token_start, s);
            if (e !== r.token_end) note_mismatch("token_end", r.token_end, e);
            if (k !== r.result_kind) note_mismatch("result_kind", r.result_kind, k);
            if (l !== r.last_result) note_mismatch("last_result", r.last_result, l);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [16:0] o_token_start;
    logic [16:0] o_token_end;
    logic [1:0]  o_result_kind;
    logic        o_last_result;

    bit           steady;
    int unsigned  cycles;
    logic [7:0]   text_q[$];
    token_tracker tracker;

    ngram_token_splitter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_token_start (o_token_start),
        .o_token_end   (o_token_end),
        .o_result_kind (o_result_kind),
        .o_last_result (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.match_result(o_token_start, o_token_end, o_result_kind, o_last_result);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Holds one byte on the input until its transfer completes.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!steady && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_byte(b, eot);
        @(negedge i_clk);
    endtask

    task automatic send_text(input bit close);
        foreach (text_q[j]) begin
            send_byte(text_q[j], close && (j == text_q.size() - 1));
        end
        text_q.delete();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic set_gram(input logic [2:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.gram = v;
    endtask

    task automatic append_chunk();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  lead;
        pick = $urandom_range(99);
        n    = $urandom_range(1, 4);
        if (pick < 22) begin
            repeat (n) text_q.push_back(8'h30 + 8'($urandom_range(9)));
        end else if (pick < 44) begin
            repeat (n) begin
                lead = $urandom_range(1) ? 8'h41 : 8'h61;
                text_q.push_back(lead + 8'($urandom_range(25)));
            end
        end else if (pick < 60) begin
            repeat (n) begin
                lead = 8'($urandom_range(32));
                text_q.push_back(($urandom_range(4) == 0) ? 8'h7F : lead);
            end
        end else if (pick < 70) begin
            text_q.push_back(Punct[$urandom_range(7)]);
        end else if (pick < 92) begin
            n = $urandom_range(2, 4);
            case (n)
                2:       lead = 8'hC0 + 8'($urandom_range(31));
                3:       lead = 8'hE0 + 8'($urandom_range(15));
                default: lead = 8'hF0 + 8'($urandom_range(7));
            endcase
            text_q.push_back(lead);
            repeat (n - 1) begin
                text_q.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                          : 8'h80 + 8'($urandom_range(63)));
            end
        end else begin
            text_q.push_back(8'($urandom));
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned target;
        int unsigned next_cfg;
        int unsigned phase;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        steady        = 1'b0;
        cycles        = 0;
        tracker       = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        text_q = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h00, 8'h7F,
                   8'hC3, 8'hA9, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text(1'b1);
        text_q = '{8'h78, 8'hFF, 8'h79};
        send_text(1'b1);
        text_q = '{8'h80};
        send_text(1'b1);
        text_q = '{8'h61, 8'hE2, 8'h82};
        send_text(1'b1);
        text_q = '{8'h20, 8'hF8};
        send_text(1'b1);
        set_gram(3'd4);
        text_q = '{8'h61, 8'h31, 8'h62, 8'h2E, 8'h63};
        send_text(1'b0);
        set_gram(3'd1);
        text_q = '{8'h2E, 8'h64};
        send_text(1'b1);

        sent     = 0;
        next_cfg = 0;
        phase    = 0;
        while (sent < RandomBytes) begin
            if (sent >= next_cfg) begin
                set_gram(GramPlan[phase % 8]);
                phase++;
                next_cfg += PhaseBytes;
            end
            steady = (sent >= 120 && sent < 180);
            target = $urandom_range(1, 14);
            while (text_q.size() < target) append_chunk();
            if ($urandom_range(6) == 0 && text_q.size() > 1) void'(text_q.pop_back());
            sent += text_q.size();
            send_text(1'b1);
        end

        set_gram(3'd1);
        steady = 1'b1;
        text_q = '{8'h31, 8'h20, 8'h62, 8'h32, 8'h63};
        send_text(1'b1);
        steady = 1'b0;

        drain();
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
